/* hw/rtl/uer_pkg.sv */
// Shared types, register codes and constants of the ultrasonic echo ranger.
package uer_pkg;

	// Register indexes of the configuration port.
	typedef enum logic [2:0] {
		REG_WINDOW    = 3'd0,
		REG_DEADBAND  = 3'd1,
		REG_MIN_EDGES = 3'd2,
		REG_EDGE_GAP  = 3'd3,
		REG_GAIN_DLY  = 3'd4,
		REG_BURST_CNT = 3'd5,
		REG_HALF_PER  = 3'd6
	} reg_idx_t;

	localparam int CFG_DATA_W = 20;
	localparam int IN_TDATA_W = 8;
	localparam int OUT_TDATA_W = 56;

	localparam logic [19:0] WINDOW_RST    = 20'd59000;
	localparam logic [19:0] DEADBAND_RST  = 20'd0;
	localparam logic [3:0]  MIN_EDGES_RST = 4'd5;
	localparam logic [11:0] EDGE_GAP_RST  = 12'd120;
	localparam logic [19:0] GAIN_DLY_RST  = 20'd2500;
	localparam logic [3:0]  BURST_CNT_RST = 4'd8;
	localparam logic [7:0]  HALF_PER_RST  = 8'd12;

	// mm per us of round trip, as a 16-bit fraction: 0.17 * 65536.
	localparam logic [13:0] RANGE_MULT = 14'd11141;
	localparam logic [17:0] RANGE_MAX  = 18'h3FFFF;
	localparam logic [3:0]  COUNT_MAX  = 4'd15;

	typedef struct packed {
		logic [19:0] window_us;
		logic [19:0] deadband_us;
		logic [3:0]  min_edges;
		logic [11:0] edge_gap_us;
		logic [19:0] high_gain_delay_us;
		logic [3:0]  burst_count;
		logic [7:0]  half_period_us;
	} cfg_t;

	typedef struct packed {
		logic [31:0] timestamp_us;
		logic        fresh;
		logic [17:0] distance_mm;
		logic        trigger_busy;
		logic        level_release;
		logic        gain_low;
		logic        tx_level;
	} res_t;

endpackage

/* hw/rtl/uer_cfg.sv */
// Configuration register file of the echo ranger.
module uer_cfg
	import uer_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [2:0]            index,
	input  logic [CFG_DATA_W-1:0] data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_us          <= WINDOW_RST;
			cfg_q.deadband_us        <= DEADBAND_RST;
			cfg_q.min_edges          <= MIN_EDGES_RST;
			cfg_q.edge_gap_us        <= EDGE_GAP_RST;
			cfg_q.high_gain_delay_us <= GAIN_DLY_RST;
			cfg_q.burst_count        <= BURST_CNT_RST;
			cfg_q.half_period_us     <= HALF_PER_RST;
		end else if (wr_en) begin
			unique case (index)
				REG_WINDOW:    cfg_q.window_us          <= data;
				REG_DEADBAND:  cfg_q.deadband_us        <= data;
				REG_MIN_EDGES: cfg_q.min_edges          <= data[3:0];
				REG_EDGE_GAP:  cfg_q.edge_gap_us        <= data[11:0];
				REG_GAIN_DLY:  cfg_q.high_gain_delay_us <= data;
				REG_BURST_CNT: cfg_q.burst_count        <= data[3:0];
				REG_HALF_PER:  cfg_q.half_period_us     <= data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/uer_core.sv */
// Per-tick measurement state and next-state logic of the echo ranger.
module uer_core
	import uer_pkg::*;
#(
	parameter int ELAPSED_WIDTH = 20,
	parameter int STAMP_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic echo_edge,
	input  logic trigger_req,
	input  logic read_req,
	input  cfg_t cfg,
	output res_t res
);

	localparam int EW = ELAPSED_WIDTH;
	localparam int CW = (EW > 20) ? EW : 20;
	localparam int PW = EW + 14;

	logic [STAMP_WIDTH-1:0] time_now_q, send_stamp_q, stamp_nx;
	logic [EW-1:0]          elapsed_q, el_nx, train_q, train_nx;
	logic signed [EW:0]     last_edge_q, ledge_nx;
	logic                   confirmed_q, conf_nx, fresh_q, fresh_nx, gain_q, gain_nx;
	logic [3:0]             ecnt_q, ecnt_nx;
	logic [17:0]            range_q, range_nx;
	logic [4:0]             burst_q, burst_nx;
	logic [7:0]             phase_q, phase_nx, half_len;
	logic                   trig_ok, busy, fresh_o;
	logic [31:0]            stamp_o;
	logic signed [EW+1:0]   gap_diff;
	logic [PW-1:0]          prod;
	logic [EW-1:0]          el_inc;

	assign half_len = (cfg.half_period_us == 8'd0) ? 8'd1 : cfg.half_period_us;

	always_comb begin
		burst_nx = burst_q;
		phase_nx = phase_q;
		stamp_nx = send_stamp_q;
		el_nx = elapsed_q;
		conf_nx = confirmed_q;
		ecnt_nx = ecnt_q;
		train_nx = train_q;
		ledge_nx = last_edge_q;
		range_nx = range_q;
		fresh_nx = fresh_q;
		gain_nx = gain_q;
		busy = 1'b0;
		fresh_o = 1'b0;
		stamp_o = 32'd0;
		trig_ok = 1'b0;
		gap_diff = '0;
		prod = '0;

		// Burst advances first.
		if (burst_q != 5'd0) begin
			if (phase_q > 8'd1) begin
				phase_nx = phase_q - 8'd1;
			end else begin
				burst_nx = burst_q - 5'd1;
				phase_nx = (burst_nx != 5'd0) ? half_len : 8'd0;
			end
		end

		if (trigger_req) begin
			if (CW'(elapsed_q) < CW'(cfg.window_us)) begin
				busy = 1'b1;
			end else begin
				trig_ok = 1'b1;
				if (!confirmed_q) begin
					fresh_nx = 1'b1;
				end
				stamp_nx = time_now_q;
				el_nx = '0;
				conf_nx = 1'b0;
				ecnt_nx = 4'd0;
				train_nx = '0;
				ledge_nx = (EW+1)'(0) - (EW+1)'(cfg.edge_gap_us);
				range_nx = 18'd0;
				gain_nx = 1'b1;
				burst_nx = {cfg.burst_count, 1'b0};
				phase_nx = (burst_nx != 5'd0) ? half_len : 8'd0;
			end
		end

		if (CW'(el_nx) > CW'(cfg.high_gain_delay_us)) begin
			gain_nx = 1'b0;
		end

		if (echo_edge && !conf_nx && burst_nx == 5'd0
				&& CW'(el_nx) >= CW'(cfg.deadband_us)) begin
			gap_diff = $signed({2'b00, el_nx}) - $signed({ledge_nx[EW], ledge_nx});
			if (gap_diff > $signed((EW+2)'(cfg.edge_gap_us))) begin
				ecnt_nx = 4'd0;
				train_nx = el_nx;
			end else if (ecnt_nx < COUNT_MAX) begin
				ecnt_nx = ecnt_nx + 4'd1;
			end
			ledge_nx = $signed({1'b0, el_nx});
			if (ecnt_nx >= cfg.min_edges) begin
				prod = PW'(train_nx) * PW'(RANGE_MULT);
				fresh_nx = 1'b1;
				conf_nx = 1'b1;
				// The product over 2^16 can exceed the 18-bit range field.
				range_nx = ((prod >> 16) > PW'(RANGE_MAX)) ? RANGE_MAX : 18'(prod >> 16);
			end
		end

		if (read_req) begin
			fresh_o = fresh_nx;
			if (fresh_nx) begin
				stamp_o = 32'(stamp_nx);
			end
			fresh_nx = 1'b0;
		end
	end

	assign el_inc = (el_nx != {EW{1'b1}}) ? el_nx + EW'(1) : el_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_now_q <= '0;
			send_stamp_q <= '0;
			elapsed_q <= '0;
			confirmed_q <= 1'b0;
			fresh_q <= 1'b0;
			ecnt_q <= 4'd0;
			train_q <= '0;
			last_edge_q <= (EW+1)'(0) - (EW+1)'(EDGE_GAP_RST);
			range_q <= 18'd0;
			burst_q <= 5'd0;
			phase_q <= 8'd0;
			gain_q <= 1'b0;
		end else if (step) begin
			time_now_q <= time_now_q + STAMP_WIDTH'(1);
			send_stamp_q <= stamp_nx;
			elapsed_q <= el_inc;
			confirmed_q <= conf_nx;
			fresh_q <= fresh_nx;
			ecnt_q <= ecnt_nx;
			train_q <= train_nx;
			last_edge_q <= ledge_nx;
			range_q <= range_nx;
			burst_q <= burst_nx;
			phase_q <= phase_nx;
			gain_q <= gain_nx;
		end
	end

	always_comb begin
		res.tx_level = (burst_nx != 5'd0) && !burst_nx[0];
		res.gain_low = gain_nx;
		res.level_release = (burst_nx == 5'd0);
		res.trigger_busy = busy;
		res.distance_mm = range_nx;
		res.fresh = fresh_o;
		res.timestamp_us = stamp_o;
	end

`ifndef ASSERT_OFF
	a_phase_live: assert property (@(posedge clk) disable iff (!arst_n)
		burst_q != 5'd0 |-> phase_q != 8'd0)
		else $error("burst running with an empty phase timer");
	a_burst_bound: assert property (@(posedge clk) disable iff (!arst_n)
		burst_q <= 5'd30)
		else $error("burst phase count out of range");
	a_trig_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && trig_ok |=> elapsed_q == EW'(1))
		else $error("accepted trigger did not restart the elapsed time");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(elapsed_q) && $stable(time_now_q) && $stable(burst_q))
		else $error("state moved without a beat");
`endif

endmodule

/* hw/rtl/ultrasonic_echo_ranger.sv */
// Top level of the ultrasonic echo ranger: input register, core and result register.
//
//   channel  | dir | width | beat
//   s_axis   | in  | 8     | one microsecond tick: echo_edge, trigger_req, read_req
//   m_axis   | out | 56    | one result per tick
//   cfg      | in  | 20    | register write, no handshake
//
// The state update runs as the beat moves from the input register into the result
// register, so one beat enters and one leaves per cycle while m_axis does not stall.
// Reset sets the registers to their documented defaults and the state to idle.
// A stall on m_axis holds the result register and the input register; s_axis
// keeps taking beats while the input register is free or draining.
module ultrasonic_echo_ranger
	import uer_pkg::*;
#(
	parameter int ELAPSED_WIDTH = 20,
	parameter int STAMP_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// bit 0 echo_edge, bit 1 trigger_req, bit 2 read_req, bits 7:3 zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// tx_level, gain_low, level_release, trigger_busy, distance_mm[17:0],
	// fresh, timestamp_us[31:0], then one zero bit
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_wr_en,
	input  logic [2:0]             cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic       in_valid_s1;
	logic [2:0] in_data_s1;
	logic       out_valid_q;
	res_t       out_q;
	res_t       res;
	cfg_t       cfg;
	logic       step;

	assign step = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				in_valid_s1 <= s_axis_tvalid;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			in_data_s1 <= s_axis_tdata[2:0];
		end
		if (step) begin
			out_q <= res;
		end
	end

	uer_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	uer_core #(
		.ELAPSED_WIDTH (ELAPSED_WIDTH),
		.STAMP_WIDTH   (STAMP_WIDTH)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.echo_edge   (in_data_s1[0]),
		.trigger_req (in_data_s1[1]),
		.read_req    (in_data_s1[2]),
		.cfg         (cfg),
		.res         (res)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {1'b0, out_q};

endmodule

/* verif/tb_top.sv */
// Testbench of the ultrasonic echo ranger: random tick streams checked against a cycle-free predictor.
module tb_top;
	import uer_pkg::*;

	localparam int IDLE_LIMIT = 5000;

	// Predicts one result per tick and checks the result beats in order.
	class ranger_model;
		cfg_t        regs;
		logic [31:0] time_now, send_stamp;
		logic [19:0] elapsed, train_start;
		longint      last_edge;
		logic [17:0] range_mm;
		logic [4:0]  burst_left;
		logic [7:0]  phase_timer;
		logic [3:0]  edge_count;
		bit          confirmed, result_fresh, gain_state;
		res_t        expected_q[$];
		int          errors, sends, echoes_confirmed;

		function new();
			regs.window_us = WINDOW_RST;
			regs.deadband_us = DEADBAND_RST;
			regs.min_edges = MIN_EDGES_RST;
			regs.edge_gap_us = EDGE_GAP_RST;
			regs.high_gain_delay_us = GAIN_DLY_RST;
			regs.burst_count = BURST_CNT_RST;
			regs.half_period_us = HALF_PER_RST;
			time_now = '0;
			send_stamp = '0;
			elapsed = '0;
			train_start = '0;
			last_edge = 0 - longint'(EDGE_GAP_RST);
			range_mm = '0;
			burst_left = '0;
			phase_timer = '0;
			edge_count = '0;
			confirmed = 0;
			result_fresh = 0;
			gain_state = 0;
			errors = 0;
			sends = 0;
			echoes_confirmed = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_WINDOW:    regs.window_us = val;
				REG_DEADBAND:  regs.deadband_us = val;
				REG_MIN_EDGES: regs.min_edges = val[3:0];
				REG_EDGE_GAP:  regs.edge_gap_us = val[11:0];
				REG_GAIN_DLY:  regs.high_gain_delay_us = val;
				REG_BURST_CNT: regs.burst_count = val[3:0];
				REG_HALF_PER:  regs.half_period_us = val[7:0];
				default: ;
			endcase
		endfunction

		function void take_tick(logic [IN_TDATA_W-1:0] beat);
			bit                echo, trig, rd;
			res_t              r;
			logic [7:0]        half;
			longint unsigned   mm;
			echo = beat[0];
			trig = beat[1];
			rd = beat[2];
			half = (regs.half_period_us == 0) ? 8'd1 : regs.half_period_us;
			r = '0;

			if (burst_left != 0) begin
				if (phase_timer > 1) begin
					phase_timer--;
				end else begin
					burst_left--;
					phase_timer = (burst_left != 0) ? half : 8'd0;
				end
			end

			if (trig) begin
				if (elapsed < regs.window_us) begin
					r.trigger_busy = 1'b1;
				end else begin
					// An unconfirmed measurement still reports a fresh zero range.
					if (!confirmed)
						result_fresh = 1;
					send_stamp = time_now;
					elapsed = '0;
					confirmed = 0;
					edge_count = '0;
					train_start = '0;
					last_edge = 0 - longint'(regs.edge_gap_us);
					range_mm = '0;
					gain_state = 1;
					burst_left = {regs.burst_count, 1'b0};
					phase_timer = (burst_left != 0) ? half : 8'd0;
					sends++;
				end
			end

			if (elapsed > regs.high_gain_delay_us)
				gain_state = 0;

			if (echo && !confirmed && burst_left == 0 && elapsed >= regs.deadband_us) begin
				if (longint'(elapsed) - last_edge > longint'(regs.edge_gap_us)) begin
					edge_count = '0;
					train_start = elapsed;
				end else if (edge_count < COUNT_MAX) begin
					edge_count++;
				end
				last_edge = longint'(elapsed);
				if (edge_count >= regs.min_edges) begin
					mm = (longint'(train_start) * RANGE_MULT) >> 16;
					result_fresh = 1;
					confirmed = 1;
					range_mm = (mm > RANGE_MAX) ? RANGE_MAX : mm[17:0];
					echoes_confirmed++;
				end
			end

			if (rd) begin
				r.fresh = result_fresh;
				if (result_fresh)
					r.timestamp_us = send_stamp;
				result_fresh = 0;
			end

			r.tx_level = (burst_left != 0) && !burst_left[0];
			r.gain_low = gain_state;
			r.level_release = (burst_left == 0);
			r.distance_mm = range_mm;
			expected_q.push_back(r);

			time_now++;
			if (elapsed != '1)
				elapsed++;
		endfunction

		function void cmp(string field, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_beat(logic [OUT_TDATA_W-1:0] beat);
			res_t got, want;
			got = res_t'(beat[$bits(res_t)-1:0]);
			if (expected_q.size() == 0) begin
				$error("result beat with no tick waiting: %h", beat);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			cmp("tx_level", want.tx_level, got.tx_level);
			cmp("gain_low", want.gain_low, got.gain_low);
			cmp("level_release", want.level_release, got.level_release);
			cmp("trigger_busy", want.trigger_busy, got.trigger_busy);
			cmp("distance_mm", want.distance_mm, got.distance_mm);
			cmp("fresh", want.fresh, got.fresh);
			cmp("timestamp_us", want.timestamp_us, got.timestamp_us);
		endfunction
	endclass

	logic                   clk, arst_n;
	logic                   s_axis_tvalid, s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid, m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_wr_en;
	logic [2:0]             cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	bit          steady;
	int          ticks_sent, settings_used;
	cfg_t        cur_cfg;
	ranger_model sb;

	ultrasonic_echo_ranger u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		m_axis_tready <= steady || ($urandom_range(99) >= 23);
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_beat(m_axis_tdata);
		if (s_axis_tvalid && s_axis_tready)
			sb.take_tick(s_axis_tdata);
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_top: FAIL");
		$finish;
	end

	function automatic bit chance(int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic cfg_t make_cfg(int window, int deadband, int min_edges, int gap,
			int gain_dly, int burst, int half);
		cfg_t c;
		c.window_us = 20'(window);
		c.deadband_us = 20'(deadband);
		c.min_edges = 4'(min_edges);
		c.edge_gap_us = 12'(gap);
		c.high_gain_delay_us = 20'(gain_dly);
		c.burst_count = 4'(burst);
		c.half_period_us = 8'(half);
		return c;
	endfunction

	task automatic send_tick(input bit echo, input bit trig, input bit rd);
		@(negedge clk);
		while (!steady && chance(23)) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'b0, rd, trig, echo};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		ticks_sent++;
	endtask

	task automatic noise(input int n, input int echo_pct, input int trig_pct, input int rd_pct);
		repeat (n)
			send_tick(chance(echo_pct), chance(trig_pct), chance(rd_pct));
	endtask

	// Stops the tick stream and waits until every predicted result has come out.
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_one(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic write_regs(input cfg_t c);
		write_one(REG_WINDOW, c.window_us);
		write_one(REG_DEADBAND, c.deadband_us);
		write_one(REG_MIN_EDGES, CFG_DATA_W'(c.min_edges));
		write_one(REG_EDGE_GAP, CFG_DATA_W'(c.edge_gap_us));
		write_one(REG_GAIN_DLY, c.high_gain_delay_us);
		write_one(REG_BURST_CNT, CFG_DATA_W'(c.burst_count));
		write_one(REG_HALF_PER, CFG_DATA_W'(c.half_period_us));
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cur_cfg = c;
		settings_used++;
	endtask

	// One measurement: trigger, wait out the burst, an echo train, then a read.
	task automatic measure();
		int half, gap, burst_ticks, n_edges, span;
		half = (cur_cfg.half_period_us == 0) ? 1 : int'(cur_cfg.half_period_us);
		gap = cur_cfg.edge_gap_us;
		burst_ticks = 2 * int'(cur_cfg.burst_count) * half;
		send_tick(chance(50), 1'b1, chance(20));
		noise(burst_ticks + $urandom_range(0, 3) + $urandom_range(0, cur_cfg.deadband_us), 8, 3, 5);
		n_edges = $urandom_range(1, int'(cur_cfg.min_edges) + 2);
		repeat (n_edges) begin
			send_tick(1'b1, chance(3), chance(5));
			// Mostly gaps inside the train; now and then one that splits it.
			span = chance(80) ? $urandom_range(0, gap - 1) : $urandom_range(gap, gap + 3);
			noise(span, 0, 2, 5);
		end
		noise($urandom_range(0, cur_cfg.window_us), 4, 4, 10);
		send_tick(chance(10), 1'b0, 1'b1);
	endtask

	task automatic run_measures(input int target);
		int start;
		start = ticks_sent;
		while (ticks_sent - start < target)
			measure();
	endtask

	initial begin
		cfg_t c;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_WINDOW;
		cfg_data = '0;
		steady = 0;
		ticks_sent = 0;
		settings_used = 1;
		cur_cfg = make_cfg(WINDOW_RST, DEADBAND_RST, MIN_EDGES_RST, EDGE_GAP_RST,
			GAIN_DLY_RST, BURST_CNT_RST, HALF_PER_RST);
		sb = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: triggers are refused for the whole startup window, but
		// echoes already count, so a train of six confirms a range.
		send_tick(0, 0, 0);
		send_tick(0, 0, 1);
		send_tick(0, 1, 0);
		send_tick(1, 1, 1);
		repeat (5) send_tick(1, 0, 0);
		send_tick(0, 0, 1);
		send_tick(0, 0, 1);
		send_tick(1, 0, 0);
		send_tick(1, 1, 1);
		send_tick(0, 1, 1);

		settle();
		write_regs(make_cfg(30, 2, 3, 5, 8, 2, 2));
		run_measures(40);
		settle();
		run_measures(40);

		// Every register at zero: no refusals, no pulses, confirm on the first edge.
		settle();
		write_regs(make_cfg(0, 0, 0, 0, 0, 0, 0));
		steady = 1;
		noise(60, 50, 30, 30);
		settle();
		steady = 0;

		// Longest window: every trigger refused, full-length echo trains.
		write_regs(make_cfg(20'hFFFFF, 0, 15, 4095, 0, 1, 1));
		noise(40, 60, 20, 10);

		repeat (2) begin
			settle();
			c = make_cfg($urandom_range(1, 60), $urandom_range(0, 6), $urandom_range(1, 6),
				$urandom_range(1, 8), $urandom_range(0, 20), $urandom_range(1, 3),
				$urandom_range(1, 3));
			write_regs(c);
			run_measures(50);
		end

		// Longest burst, echoes never past the deadband, gain never goes high.
		settle();
		write_regs(make_cfg(1, 20'hFFFFF, 15, 4095, 20'hFFFFF, 15, 255));
		send_tick(0, 1, 0);
		noise(60, 20, 0, 2);

		settle();
		$display("tb_top: %0d ticks under %0d register settings", ticks_sent, settings_used);
		$display("tb_top: %0d measurements started, %0d echoes confirmed",
			sb.sends, sb.echoes_confirmed);
		if (sb.errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
